### sv/v3au_pkg.sv
// Shared types and constants for the three-component vector arithmetic unit.
package v3au_pkg;

    localparam int FRAC_BITS_DEF  = 8;
    localparam int COMP_WIDTH_DEF = 16;
    localparam int OUT_W          = 40;
    localparam int CMD_W          = 3;
    localparam int STAT_W         = 2;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_MAG   = 3'd0,
        CMD_SCALE = 3'd1,
        CMD_ADD   = 3'd2,
        CMD_DOT   = 3'd3,
        CMD_CROSS = 3'd4,
        CMD_PROJ  = 3'd5,
        CMD_AREA  = 3'd6,
        CMD_NOP   = 3'd7
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2,
        ST_RSV  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_SQRT = 2'd1,
        BK_DIV  = 2'd2,
        BK_DONE = 2'd3
    } bk_state_t;

endpackage

### sv/v3au_front.sv
// Front end: accepts commands, computes products and sums, fills the work queue.
module v3au_front
    import v3au_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cmd_t                           in_cmd,
    input  logic signed [COMP_WIDTH-1:0]   u_x,
    input  logic signed [COMP_WIDTH-1:0]   u_y,
    input  logic signed [COMP_WIDTH-1:0]   u_z,
    input  logic signed [COMP_WIDTH-1:0]   v_x,
    input  logic signed [COMP_WIDTH-1:0]   v_y,
    input  logic signed [COMP_WIDTH-1:0]   v_z,
    input  logic signed [COMP_WIDTH-1:0]   sf,
    output logic                           q_valid,
    input  logic                           q_ready,
    output cmd_t                           q_cmd,
    output logic signed [2*COMP_WIDTH+1:0] q_a0,
    output logic signed [2*COMP_WIDTH+1:0] q_a1,
    output logic signed [2*COMP_WIDTH+1:0] q_a2,
    output logic signed [COMP_WIDTH-1:0]   q_v0,
    output logic signed [COMP_WIDTH-1:0]   q_v1,
    output logic signed [COMP_WIDTH-1:0]   q_v2,
    output logic signed [2*COMP_WIDTH+1:0] q_dot,
    output logic        [2*COMP_WIDTH+1:0] q_nv
);

    localparam int PW = 2*COMP_WIDTH + 2;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    // stage 1: products
    logic               s1_valid_reg;
    cmd_t               s1_cmd_reg;
    logic signed [PW-1:0] p_reg [0:8];
    logic signed [COMP_WIDTH-1:0] s1_v_reg [0:2];
    logic signed [COMP_WIDTH:0]   s1_sum_reg [0:2];

    // queue
    cmd_t                  qc_reg  [0:QUEUE_DEPTH-1];
    logic signed [PW-1:0]  qa_reg  [0:QUEUE_DEPTH-1][0:2];
    logic signed [COMP_WIDTH-1:0] qv_reg [0:QUEUE_DEPTH-1][0:2];
    logic signed [PW-1:0]  qd_reg  [0:QUEUE_DEPTH-1];
    logic        [PW-1:0]  qn_reg  [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0]      wp_reg, rp_reg;
    logic [PTR_W:0]        cnt_reg;

    logic s1_go, q_push, q_pop;
    logic signed [PW-1:0] a_next [0:2];
    logic signed [PW-1:0] dot_next;
    logic        [PW-1:0] nv_next;

    assign q_push   = s1_valid_reg && (cnt_reg != QUEUE_DEPTH[PTR_W:0]);
    assign s1_go    = !s1_valid_reg || q_push;
    assign in_ready = s1_go;
    assign q_pop    = q_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_go)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && in_valid)
        begin
            s1_cmd_reg <= in_cmd;
            s1_v_reg[0] <= v_x;
            s1_v_reg[1] <= v_y;
            s1_v_reg[2] <= v_z;
            s1_sum_reg[0] <= (COMP_WIDTH+1)'(u_x) + (COMP_WIDTH+1)'(v_x);
            s1_sum_reg[1] <= (COMP_WIDTH+1)'(u_y) + (COMP_WIDTH+1)'(v_y);
            s1_sum_reg[2] <= (COMP_WIDTH+1)'(u_z) + (COMP_WIDTH+1)'(v_z);
            case (in_cmd)
                CMD_SCALE:
                begin
                    p_reg[0] <= PW'(u_x * sf);
                    p_reg[1] <= PW'(u_y * sf);
                    p_reg[2] <= PW'(u_z * sf);
                end
                CMD_MAG:
                begin
                    p_reg[0] <= PW'(u_x * u_x);
                    p_reg[1] <= PW'(u_y * u_y);
                    p_reg[2] <= PW'(u_z * u_z);
                end
                default:
                begin
                    p_reg[0] <= PW'(u_y * v_z);
                    p_reg[1] <= PW'(u_z * v_x);
                    p_reg[2] <= PW'(u_x * v_y);
                end
            endcase
            p_reg[3] <= PW'(u_z * v_y);
            p_reg[4] <= PW'(u_x * v_z);
            p_reg[5] <= PW'(u_y * v_x);
            p_reg[6] <= PW'(u_x * v_x);
            p_reg[7] <= PW'(u_y * v_y);
            p_reg[8] <= PW'(u_z * v_z);
        end
    end

    always_comb
    begin
        dot_next = p_reg[6] + p_reg[7] + p_reg[8];
        nv_next  = PW'(s1_v_reg[0] * s1_v_reg[0]) + PW'(s1_v_reg[1] * s1_v_reg[1])
                 + PW'(s1_v_reg[2] * s1_v_reg[2]);
        case (s1_cmd_reg)
            CMD_MAG, CMD_SCALE:
            begin
                a_next[0] = p_reg[0];
                a_next[1] = p_reg[1];
                a_next[2] = p_reg[2];
            end
            CMD_ADD:
            begin
                a_next[0] = PW'(s1_sum_reg[0]);
                a_next[1] = PW'(s1_sum_reg[1]);
                a_next[2] = PW'(s1_sum_reg[2]);
            end
            default:
            begin
                a_next[0] = p_reg[0] - p_reg[3];
                a_next[1] = p_reg[1] - p_reg[4];
                a_next[2] = p_reg[2] - p_reg[5];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (q_push)
                wp_reg <= (wp_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (q_pop)
                rp_reg <= (rp_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PTR_W+1)'(q_push) - (PTR_W+1)'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            qc_reg[wp_reg] <= s1_cmd_reg;
            qd_reg[wp_reg] <= dot_next;
            qn_reg[wp_reg] <= nv_next;
            for (int i = 0; i < 3; i++)
            begin
                qa_reg[wp_reg][i] <= a_next[i];
                qv_reg[wp_reg][i] <= s1_v_reg[i];
            end
        end
    end

    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = qc_reg[rp_reg];
    assign q_a0    = qa_reg[rp_reg][0];
    assign q_a1    = qa_reg[rp_reg][1];
    assign q_a2    = qa_reg[rp_reg][2];
    assign q_v0    = qv_reg[rp_reg][0];
    assign q_v1    = qv_reg[rp_reg][1];
    assign q_v2    = qv_reg[rp_reg][2];
    assign q_dot   = qd_reg[rp_reg];
    assign q_nv    = qn_reg[rp_reg];

endmodule

### sv/v3au_back.sv
// Back end: square root, division, saturation and the result register.
module v3au_back
    import v3au_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  cmd_t                           q_cmd,
    input  logic signed [2*COMP_WIDTH+1:0] q_a0,
    input  logic signed [2*COMP_WIDTH+1:0] q_a1,
    input  logic signed [2*COMP_WIDTH+1:0] q_a2,
    input  logic signed [COMP_WIDTH-1:0]   q_v0,
    input  logic signed [COMP_WIDTH-1:0]   q_v1,
    input  logic signed [COMP_WIDTH-1:0]   q_v2,
    input  logic signed [2*COMP_WIDTH+1:0] q_dot,
    input  logic        [2*COMP_WIDTH+1:0] q_nv,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [OUT_W-1:0]        w_x,
    output logic signed [OUT_W-1:0]        w_y,
    output logic signed [OUT_W-1:0]        w_z,
    output logic signed [OUT_W-1:0]        s_out,
    output status_t                        stat
);

    localparam int PW   = 2*COMP_WIDTH + 2;
    // radicand: area uses up to 2*PW+2 bits; magnitude shifts by 2*FRAC
    localparam int RW0  = 2*PW + 2;
    localparam int RW1  = PW + 2*FRAC_BITS + 2;
    localparam int SQ_STEPS = 2;
    localparam int RADW = ((RW0 > RW1 ? RW0 : RW1) + 2*SQ_STEPS - 1) / (2*SQ_STEPS)
                          * (2*SQ_STEPS);
    localparam int ROOTW = RADW / 2;
    localparam int SQ_CYC = ROOTW / SQ_STEPS;
    localparam int DIV_STEPS = 4;
    localparam int NUMW = (PW + COMP_WIDTH + FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS
                          * DIV_STEPS;
    localparam int DV_CYC = NUMW / DIV_STEPS;
    localparam int CW = $clog2((SQ_CYC > DV_CYC ? SQ_CYC : DV_CYC) + 1);
    localparam logic signed [OUT_W-1:0] OMAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OMIN = {1'b1, {(OUT_W-1){1'b0}}};

    bk_state_t state_reg, state_next;
    cmd_t      cmd_reg;
    logic [CW-1:0] cnt_reg;
    logic [RADW-1:0]  rad_reg;
    logic [ROOTW+1:0] rem_reg;
    logic [ROOTW-1:0] root_reg;
    logic [NUMW-1:0]  num_reg [0:2];
    logic [PW:0]      drem_reg [0:2];
    logic [PW-1:0]    den_reg;
    logic             neg_reg [0:2];
    logic             sat_reg, zero_reg;
    logic signed [OUT_W-1:0] wx_reg, wy_reg, wz_reg, so_reg;
    status_t          stat_reg;
    logic             ov_reg;

    logic take, fin_ok, load, busy_done;
    logic signed [PW-1:0] a [0:2];
    logic [PW-1:0] am [0:2];
    logic [2*PW-1:0] sq [0:2];
    logic [RADW-1:0] rad_new;
    logic [PW-1:0] dm;
    logic dneg;
    logic [COMP_WIDTH-1:0] vm [0:2];
    logic signed [OUT_W-1:0] r_vec [0:2];
    logic signed [OUT_W-1:0] r_sc;
    logic r_sat, r_big;

    logic [RADW-1:0]  s_rad;
    logic [ROOTW+1:0] s_rem;
    logic [ROOTW-1:0] s_root;
    logic [ROOTW+1:0] trial;
    logic [NUMW-1:0]  d_num [0:2];
    logic [PW:0]      d_rem [0:2];

    function automatic logic signed [OUT_W-1:0] clamp_s(input logic signed [PW+FRAC_BITS:0] x,
                                                        output logic sat);
        logic signed [PW+FRAC_BITS+OUT_W:0] xe;
        begin
            xe = (PW+FRAC_BITS+OUT_W+1)'(x);
            sat = 1'b0;
            if (xe > (PW+FRAC_BITS+OUT_W+1)'(OMAX))
            begin
                sat = 1'b1;
                return OMAX;
            end
            if (xe < (PW+FRAC_BITS+OUT_W+1)'(OMIN))
            begin
                sat = 1'b1;
                return OMIN;
            end
            return OUT_W'(xe);
        end
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_m(input logic neg,
                                                        input logic [NUMW+RADW-1:0] m,
                                                        output logic sat);
        begin
            sat = 1'b0;
            if (!neg)
            begin
                if (m > (NUMW+RADW)'(OMAX))
                begin
                    sat = 1'b1;
                    return OMAX;
                end
                return OUT_W'(m);
            end
            if (m > (NUMW+RADW)'(OMAX) + 1'b1)
            begin
                sat = 1'b1;
                return OMIN;
            end
            return OUT_W'(-m);
        end
    endfunction

    assign take    = q_valid && q_ready;
    assign fin_ok  = !ov_reg || out_ready;
    assign q_ready = (state_reg == BK_IDLE) && fin_ok;
    assign a[0] = q_a0;
    assign a[1] = q_a1;
    assign a[2] = q_a2;
    assign dneg = q_dot[PW-1];
    assign dm   = dneg ? PW'(-q_dot) : PW'(q_dot);
    assign vm[0] = q_v0[COMP_WIDTH-1] ? COMP_WIDTH'(-q_v0) : COMP_WIDTH'(q_v0);
    assign vm[1] = q_v1[COMP_WIDTH-1] ? COMP_WIDTH'(-q_v1) : COMP_WIDTH'(q_v1);
    assign vm[2] = q_v2[COMP_WIDTH-1] ? COMP_WIDTH'(-q_v2) : COMP_WIDTH'(q_v2);

    always_comb
    begin
        r_big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            am[i] = a[i][PW-1] ? PW'(-a[i]) : PW'(a[i]);
            sq[i] = (2*PW)'(am[i]) * (2*PW)'(am[i]);
            if ((OUT_W+PW)'(am[i]) > (OUT_W+PW)'(OMAX))
                r_big = 1'b1;
        end
        if (q_cmd == CMD_MAG)
            rad_new = (RADW'(am[0]) + RADW'(am[1]) + RADW'(am[2])) << (2*FRAC_BITS);
        else
            rad_new = RADW'(sq[0]) + RADW'(sq[1]) + RADW'(sq[2]);
    end

    // direct results
    always_comb
    begin
        logic s0, s1, s2, s3;
        s0 = 1'b0;
        s1 = 1'b0;
        s2 = 1'b0;
        s3 = 1'b0;
        r_vec[0] = '0;
        r_vec[1] = '0;
        r_vec[2] = '0;
        r_sc = '0;
        case (q_cmd)
            CMD_SCALE, CMD_CROSS:
            begin
                r_vec[0] = clamp_s((PW+FRAC_BITS+1)'(a[0]), s0);
                r_vec[1] = clamp_s((PW+FRAC_BITS+1)'(a[1]), s1);
                r_vec[2] = clamp_s((PW+FRAC_BITS+1)'(a[2]), s2);
            end
            CMD_ADD:
            begin
                r_vec[0] = clamp_s((PW+FRAC_BITS+1)'(a[0]) <<< FRAC_BITS, s0);
                r_vec[1] = clamp_s((PW+FRAC_BITS+1)'(a[1]) <<< FRAC_BITS, s1);
                r_vec[2] = clamp_s((PW+FRAC_BITS+1)'(a[2]) <<< FRAC_BITS, s2);
            end
            CMD_DOT:
                r_sc = clamp_s((PW+FRAC_BITS+1)'(q_dot), s3);
            default:
            begin
            end
        endcase
        r_sat = s0 | s1 | s2 | s3;
    end

    always_comb
    begin
        s_rad  = rad_reg;
        s_rem  = rem_reg;
        s_root = root_reg;
        trial  = '0;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            s_rem = {s_rem[ROOTW-1:0], s_rad[RADW-1 -: 2]};
            s_rad = s_rad << 2;
            trial = {s_root, 2'b01};
            if (s_rem >= trial)
            begin
                s_rem  = s_rem - trial;
                s_root = {s_root[ROOTW-2:0], 1'b1};
            end
            else
                s_root = {s_root[ROOTW-2:0], 1'b0};
        end
        for (int i = 0; i < 3; i++)
        begin
            d_num[i] = num_reg[i];
            d_rem[i] = drem_reg[i];
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                d_rem[i] = {d_rem[i][PW-1:0], d_num[i][NUMW-1]};
                if (d_rem[i] >= (PW+1)'(den_reg))
                begin
                    d_rem[i] = d_rem[i] - (PW+1)'(den_reg);
                    d_num[i] = {d_num[i][NUMW-2:0], 1'b1};
                end
                else
                    d_num[i] = {d_num[i][NUMW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (take)
                begin
                    if ((q_cmd == CMD_MAG) || (q_cmd == CMD_AREA && !r_big))
                        state_next = BK_SQRT;
                    else if (q_cmd == CMD_PROJ && q_nv != '0)
                        state_next = BK_DIV;
                end
            BK_SQRT:
                if (cnt_reg == CW'(SQ_CYC-1))
                    state_next = BK_DONE;
            BK_DIV:
                if (cnt_reg == CW'(DV_CYC-1))
                    state_next = BK_DONE;
            BK_DONE:
                if (fin_ok)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    assign load = (state_reg == BK_DONE) && fin_ok;
    assign busy_done = take && (state_next == BK_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_IDLE || state_next != state_reg)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 1'b1;
            if (busy_done || load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg  <= q_cmd;
            rad_reg  <= rad_new;
            rem_reg  <= '0;
            root_reg <= '0;
            den_reg  <= q_nv;
            num_reg[0] <= (NUMW'(vm[0]) * NUMW'(dm)) << FRAC_BITS;
            num_reg[1] <= (NUMW'(vm[1]) * NUMW'(dm)) << FRAC_BITS;
            num_reg[2] <= (NUMW'(vm[2]) * NUMW'(dm)) << FRAC_BITS;
            neg_reg[0] <= q_v0[COMP_WIDTH-1] ^ dneg;
            neg_reg[1] <= q_v1[COMP_WIDTH-1] ^ dneg;
            neg_reg[2] <= q_v2[COMP_WIDTH-1] ^ dneg;
            for (int i = 0; i < 3; i++)
                drem_reg[i] <= '0;
            zero_reg <= (q_cmd == CMD_PROJ) && (q_nv == '0);
            sat_reg  <= (q_cmd == CMD_AREA) && r_big;
        end
        else if (state_reg == BK_SQRT)
        begin
            rad_reg  <= s_rad;
            rem_reg  <= s_rem;
            root_reg <= s_root;
        end
        else if (state_reg == BK_DIV)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i]  <= d_num[i];
                drem_reg[i] <= d_rem[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic t0, t1, t2, t3;
        logic signed [OUT_W-1:0] c0, c1, c2, c3;
        if (busy_done)
        begin
            wx_reg <= r_vec[0];
            wy_reg <= r_vec[1];
            wz_reg <= r_vec[2];
            if (q_cmd == CMD_AREA && r_big)
            begin
                so_reg   <= OMAX;
                stat_reg <= ST_SAT;
            end
            else if (q_cmd == CMD_PROJ)
            begin
                so_reg   <= '0;
                stat_reg <= ST_ZERO;
            end
            else
            begin
                so_reg   <= r_sc;
                stat_reg <= r_sat ? ST_SAT : ST_OK;
            end
        end
        else if (load)
        begin
            t0 = 1'b0;
            t1 = 1'b0;
            t2 = 1'b0;
            t3 = 1'b0;
            c0 = '0;
            c1 = '0;
            c2 = '0;
            c3 = '0;
            if (cmd_reg == CMD_PROJ)
            begin
                c0 = clamp_m(neg_reg[0], (NUMW+RADW)'(num_reg[0]), t0);
                c1 = clamp_m(neg_reg[1], (NUMW+RADW)'(num_reg[1]), t1);
                c2 = clamp_m(neg_reg[2], (NUMW+RADW)'(num_reg[2]), t2);
            end
            else
                c3 = clamp_m(1'b0, (NUMW+RADW)'(root_reg), t3);
            wx_reg <= c0;
            wy_reg <= c1;
            wz_reg <= c2;
            so_reg <= c3;
            stat_reg <= (t0 | t1 | t2 | t3 | sat_reg) ? ST_SAT : ST_OK;
        end
    end

    assign out_valid = ov_reg;
    assign w_x   = wx_reg;
    assign w_y   = wy_reg;
    assign w_z   = wz_reg;
    assign s_out = so_reg;
    assign stat  = stat_reg;

endmodule

### sv/vector3_arith_unit_core.sv
// Top level of the three-component vector arithmetic unit.
// Each command returns one result. The front end registers products and sums in stage 1 and
// feeds a two-entry queue; the back end finishes scale, add, dot, cross, no-op, projection
// onto a zero vector and area with a component beyond the output range directly into the result
// register, so these stream one per cycle while the output is not stalled, passing stage 1, the
// queue and the result register. Magnitude and other area run a 2-bit-per-cycle square root
// (state SQRT) and projection a 4-bit-per-cycle divider (state DIV), each followed by state DONE,
// which loads the result register; the back end takes no new command until it is back in IDLE.
// A result waiting at the output stalls the back end, and the queue then fills and stalls the input.
module vector3_arith_unit_core
    import v3au_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // cmd[2:0], ux, uy, uz, vx, vy, vz, scale_factor, zero fill
    input  logic [((CMD_W+7*COMP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // wx[39:0], wy, wz, scalar_out, status, zero fill
    output logic [((4*OUT_W+STAT_W+7)/8)*8-1:0] m_axis_tdata
);

    localparam int PW = 2*COMP_WIDTH + 2;
    localparam int OW = ((4*OUT_W+STAT_W+7)/8)*8;

    logic q_valid, q_ready;
    cmd_t q_cmd;
    logic signed [PW-1:0] q_a0, q_a1, q_a2, q_dot;
    logic        [PW-1:0] q_nv;
    logic signed [COMP_WIDTH-1:0] q_v0, q_v1, q_v2;
    logic signed [OUT_W-1:0] w_x, w_y, w_z, s_out;
    status_t stat;

    v3au_front #(.FRAC_BITS(FRAC_BITS), .COMP_WIDTH(COMP_WIDTH)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (cmd_t'(s_axis_tdata[CMD_W-1:0])),
        .u_x      (s_axis_tdata[CMD_W+0*COMP_WIDTH +: COMP_WIDTH]),
        .u_y      (s_axis_tdata[CMD_W+1*COMP_WIDTH +: COMP_WIDTH]),
        .u_z      (s_axis_tdata[CMD_W+2*COMP_WIDTH +: COMP_WIDTH]),
        .v_x      (s_axis_tdata[CMD_W+3*COMP_WIDTH +: COMP_WIDTH]),
        .v_y      (s_axis_tdata[CMD_W+4*COMP_WIDTH +: COMP_WIDTH]),
        .v_z      (s_axis_tdata[CMD_W+5*COMP_WIDTH +: COMP_WIDTH]),
        .sf       (s_axis_tdata[CMD_W+6*COMP_WIDTH +: COMP_WIDTH]),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .q_a0     (q_a0),
        .q_a1     (q_a1),
        .q_a2     (q_a2),
        .q_v0     (q_v0),
        .q_v1     (q_v1),
        .q_v2     (q_v2),
        .q_dot    (q_dot),
        .q_nv     (q_nv)
    );

    v3au_back #(.FRAC_BITS(FRAC_BITS), .COMP_WIDTH(COMP_WIDTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .q_a0      (q_a0),
        .q_a1      (q_a1),
        .q_a2      (q_a2),
        .q_v0      (q_v0),
        .q_v1      (q_v1),
        .q_v2      (q_v2),
        .q_dot     (q_dot),
        .q_nv      (q_nv),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .w_x       (w_x),
        .w_y       (w_y),
        .w_z       (w_z),
        .s_out     (s_out),
        .stat      (stat)
    );

    assign m_axis_tdata = OW'({stat, s_out, w_z, w_y, w_x});

endmodule
